FILE: hw/rtl/occgs_pkg.sv
// Shared defaults for the occupancy grid greedy step block.
package occgs_pkg;

    // Default grid geometry
    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;
    localparam int CELL_SIZE_DEF = 8;

    // Width of one tile state entry
    localparam int TILE_W = 2;

endpackage

FILE: hw/rtl/occgs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module occgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/occupancy_grid_greedy_step.sv
// Top level of the occupancy grid greedy step block.
// Keeps a GRID_ROWS x GRID_COLS map of tile states (empty, blocked, occupied) in a
// synchronous RAM and per-column black pixel counts in a second RAM. Pixel items arrive
// in raster order; when the last pixel of a tile arrives the tile becomes blocked if more
// than 5 percent of its pixels were black. Pixel and occupy items are taken one per cycle
// while no clear or step query is under way: the column count is read in the accept cycle
// and written back the cycle after, with a forwarding register covering back-to-back pixels
// of the same tile column. A step query holds off the input until its result is registered;
// the four neighbour tiles are read one by one through the single read port of the tile RAM.
// After reset the block clears both RAMs and takes no item until that is done. A finished
// result sits in an output register, so pixel and occupy items keep flowing while it waits
// to be taken.
module occupancy_grid_greedy_step
    import occgs_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int CELL_SIZE = CELL_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic               pixel_is_black,
    input  logic [3:0]         cell_row,
    input  logic [3:0]         cell_col,
    input  logic signed [10:0] from_x,
    input  logic signed [10:0] from_y,
    input  logic signed [10:0] to_x,
    input  logic signed [10:0] to_y,
    input  logic [7:0]         tie_pick,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         next_row,
    output logic [3:0]         next_col,
    output logic               moved
);

    localparam int RW     = $clog2(GRID_ROWS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int TILES  = GRID_ROWS * GRID_COLS;
    localparam int AW     = $clog2(TILES);
    localparam int OW     = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;
    localparam int NPIX   = CELL_SIZE * CELL_SIZE;
    localparam int KW     = $clog2(NPIX + 1);
    localparam int THRESH = NPIX / 20;
    localparam int SH     = 10 + $clog2(CELL_SIZE);
    localparam int RECIP  = ((1 << SH) + CELL_SIZE - 1) / CELL_SIZE;
    localparam int MW     = $clog2(RECIP + 1);
    localparam int PW     = 10 + MW;
    localparam int DW     = $clog2(GRID_ROWS + GRID_COLS - 1);
    localparam int NB     = 4;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_OCCUPY = 2'd1,
        OP_STEP   = 2'd2
    } op_t;

    typedef enum logic [TILE_W-1:0] {
        TILE_EMPTY    = 2'd0,
        TILE_BLOCKED  = 2'd1,
        TILE_OCCUPIED = 2'd2
    } tile_t;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_TILE = 6'b000100,
        S_READ = 6'b001000,
        S_MIN  = 6'b010000,
        S_SEL  = 6'b100000
    } state_t;

    // Linear tile address from row and column
    function automatic logic [AW-1:0] tile_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        tile_addr = AW'(AW'(r) * AW'(GRID_COLS)) + AW'(c);
    endfunction

    // Pixel coordinate to tile index: negative gives 0, past the end gives the last tile
    function automatic logic [9:0] clamp_tile(input logic neg, input logic [PW-1:0] prod,
                                              input logic [9:0] lim);
        logic [9:0] q;
        q = 10'(prod >> SH);
        if (neg)
        begin
            clamp_tile = '0;
        end
        else if (q >= lim)
        begin
            clamp_tile = lim - 10'd1;
        end
        else
        begin
            clamp_tile = q;
        end
    endfunction

    // 8-bit value modulo 3 by folding base-4 digits
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        mod3 = t[1:0];
    endfunction

    // Control registers
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [OW-1:0]   px_off_reg, px_off_next;
    logic [OW-1:0]   py_off_reg, py_off_next;
    logic [CW-1:0]   tcol_reg, tcol_next;
    logic [RW-1:0]   trow_reg, trow_next;
    logic            s1_vld_reg, s1_vld_next;
    logic            fwd_vld_reg, fwd_vld_next;
    logic [2:0]      rd_k_reg, rd_k_next;
    logic            rsp_vld_reg, rsp_vld_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic            s1_pix_reg;
    logic            s1_black_reg;
    logic            s1_last_reg;
    logic [CW-1:0]   s1_tc_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [CW-1:0]   fwd_addr_reg;
    logic [KW-1:0]   fwd_data_reg;
    logic [PW-1:0]   prod_fx_reg, prod_fy_reg, prod_tx_reg, prod_ty_reg;
    logic            neg_fx_reg, neg_fy_reg, neg_tx_reg, neg_ty_reg;
    logic [7:0]      tie_reg;
    logic [RW-1:0]   si_reg, ei_reg;
    logic [CW-1:0]   sj_reg, ej_reg;
    logic [1:0]      rsp_k_reg;
    logic [NB-1:0]   cand_reg;
    logic [DW-1:0]   cost_reg [NB];
    logic [NB-1:0]   tie_mask_reg;
    logic [2:0]      tcnt_reg;
    logic [RW-1:0]   out_row_reg;
    logic [CW-1:0]   out_col_reg;
    logic            out_moved_reg;

    // Combinational signals
    logic            acc, pix_acc, occ_acc, step_acc;
    logic            occ_in_range;
    logic            pix_last;
    logic            out_free;
    logic            tile_we, tile_re;
    logic [AW-1:0]   tile_waddr, tile_raddr;
    logic [TILE_W-1:0] tile_wdata, tile_rdata;
    logic            cnt_we;
    logic [CW-1:0]   cnt_waddr;
    logic [KW-1:0]   cnt_wdata, cnt_rdata, cnt_cur, cnt_sum;
    logic [RW-1:0]   nb_r [NB];
    logic [CW-1:0]   nb_c [NB];
    logic [NB-1:0]   nb_in;
    logic [DW-1:0]   nb_cost [NB];
    logic [AW-1:0]   nb_addr [NB];
    logic            same_tile;
    logic [NB-1:0]   min_mask, min_tie;
    logic [DW-1:0]   min_best;
    logic [2:0]      min_cnt;
    logic [1:0]      pick;
    logic [2:0]      seen;
    logic            sel_found;
    logic [1:0]      sel_k;

    // Input handshake and item decode
    assign in_ready     = (state_reg == S_IDLE);
    assign acc          = in_valid && in_ready;
    assign occ_in_range = (9'(cell_row) < 9'(GRID_ROWS)) && (9'(cell_col) < 9'(GRID_COLS));
    assign pix_acc      = acc && (op_t'(operation) == OP_PIXEL);
    assign occ_acc      = acc && (op_t'(operation) == OP_OCCUPY) && occ_in_range;
    assign step_acc     = acc && (op_t'(operation) == OP_STEP);
    assign pix_last     = (px_off_reg == OW'(CELL_SIZE - 1)) &&
                          (py_off_reg == OW'(CELL_SIZE - 1));
    assign out_free     = !out_valid_reg || out_ready;

    // Raster position advance
    always_comb
    begin
        px_off_next = px_off_reg;
        py_off_next = py_off_reg;
        tcol_next   = tcol_reg;
        trow_next   = trow_reg;
        if (pix_acc)
        begin
            if (px_off_reg == OW'(CELL_SIZE - 1))
            begin
                px_off_next = '0;
                if (tcol_reg == CW'(GRID_COLS - 1))
                begin
                    tcol_next = '0;
                    if (py_off_reg == OW'(CELL_SIZE - 1))
                    begin
                        py_off_next = '0;
                        trow_next   = (trow_reg == RW'(GRID_ROWS - 1)) ? '0 :
                                      trow_reg + RW'(1);
                    end
                    else
                    begin
                        py_off_next = py_off_reg + OW'(1);
                    end
                end
                else
                begin
                    tcol_next = tcol_reg + CW'(1);
                end
            end
            else
            begin
                px_off_next = px_off_reg + OW'(1);
            end
        end
    end

    // Column count update with forwarding of the previous write
    assign cnt_cur = (fwd_vld_reg && (fwd_addr_reg == s1_tc_reg)) ? fwd_data_reg : cnt_rdata;
    assign cnt_sum = cnt_cur + KW'(s1_black_reg);

    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            cnt_we    = (clr_reg < AW'(GRID_COLS));
            cnt_waddr = clr_reg[CW-1:0];
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we    = s1_vld_reg && s1_pix_reg;
            cnt_waddr = s1_tc_reg;
            cnt_wdata = s1_last_reg ? '0 : cnt_sum;
        end
    end

    // Tile map write: clearing sweep, completed tile or occupy
    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            tile_we    = 1'b1;
            tile_waddr = clr_reg;
            tile_wdata = TILE_EMPTY;
        end
        else
        begin
            tile_we    = s1_vld_reg && (!s1_pix_reg || s1_last_reg);
            tile_waddr = s1_addr_reg;
            if (!s1_pix_reg)
            begin
                tile_wdata = TILE_OCCUPIED;
            end
            else if (cnt_sum > KW'(THRESH))
            begin
                tile_wdata = TILE_BLOCKED;
            end
            else
            begin
                tile_wdata = TILE_EMPTY;
            end
        end
    end

    // Neighbours of the start tile in the order up, down, left, right
    always_comb
    begin
        nb_r[0] = si_reg - RW'(1);
        nb_c[0] = sj_reg;
        nb_r[1] = si_reg + RW'(1);
        nb_c[1] = sj_reg;
        nb_r[2] = si_reg;
        nb_c[2] = sj_reg - CW'(1);
        nb_r[3] = si_reg;
        nb_c[3] = sj_reg + CW'(1);
        nb_in[0] = (si_reg != '0);
        nb_in[1] = (si_reg != RW'(GRID_ROWS - 1));
        nb_in[2] = (sj_reg != '0);
        nb_in[3] = (sj_reg != CW'(GRID_COLS - 1));
        for (int k = 0; k < NB; k++)
        begin
            nb_cost[k] = DW'((nb_r[k] > ei_reg) ? nb_r[k] - ei_reg : ei_reg - nb_r[k]) +
                         DW'((nb_c[k] > ej_reg) ? nb_c[k] - ej_reg : ej_reg - nb_c[k]);
            nb_addr[k] = nb_in[k] ? tile_addr(nb_r[k], nb_c[k]) : '0;
        end
    end

    // Neighbour read issue
    assign tile_re    = (state_reg == S_READ) && (rd_k_reg < 3'(NB));
    assign tile_raddr = nb_addr[rd_k_reg[1:0]];

    // Cheapest candidates
    assign same_tile = (si_reg == ei_reg) && (sj_reg == ej_reg);
    always_comb
    begin
        min_mask = same_tile ? '0 : cand_reg;
        min_best = '1;
        min_cnt  = '0;
        for (int k = 0; k < NB; k++)
        begin
            if (min_mask[k] && (cost_reg[k] < min_best))
            begin
                min_best = cost_reg[k];
            end
        end
        for (int k = 0; k < NB; k++)
        begin
            min_tie[k] = min_mask[k] && (cost_reg[k] == min_best);
            if (min_tie[k])
            begin
                min_cnt = min_cnt + 3'd1;
            end
        end
    end

    // Tie pick: tie value modulo the number of cheapest candidates
    always_comb
    begin
        case (tcnt_reg)
            3'd2:    pick = {1'b0, tie_reg[0]};
            3'd3:    pick = mod3(tie_reg);
            3'd4:    pick = tie_reg[1:0];
            default: pick = 2'd0;
        endcase
        seen      = '0;
        sel_found = 1'b0;
        sel_k     = '0;
        for (int k = 0; k < NB; k++)
        begin
            if (tie_mask_reg[k] && !sel_found)
            begin
                if (seen == 3'(pick))
                begin
                    sel_found = 1'b1;
                    sel_k     = 2'(k);
                end
                seen = seen + 3'd1;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rd_k_next      = rd_k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(TILES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (step_acc)
                begin
                    state_next = S_TILE;
                end
            end
            S_TILE:
            begin
                rd_k_next  = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (rd_k_reg == 3'(NB))
                begin
                    state_next = S_MIN;
                end
                else
                begin
                    rd_k_next = rd_k_reg + 3'd1;
                end
            end
            S_MIN:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s1_vld_next  = pix_acc || occ_acc;
    assign fwd_vld_next = s1_vld_reg && s1_pix_reg;
    assign rsp_vld_next = tile_re;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            px_off_reg    <= '0;
            py_off_reg    <= '0;
            tcol_reg      <= '0;
            trow_reg      <= '0;
            s1_vld_reg    <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            rd_k_reg      <= '0;
            rsp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            px_off_reg    <= px_off_next;
            py_off_reg    <= py_off_next;
            tcol_reg      <= tcol_next;
            trow_reg      <= trow_next;
            s1_vld_reg    <= s1_vld_next;
            fwd_vld_reg   <= fwd_vld_next;
            rd_k_reg      <= rd_k_next;
            rsp_vld_reg   <= rsp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // write-back stage for pixel and occupy items
        s1_pix_reg   <= pix_acc;
        s1_black_reg <= pixel_is_black;
        s1_last_reg  <= pix_last;
        s1_tc_reg    <= tcol_reg;
        s1_addr_reg  <= pix_acc ? tile_addr(trow_reg, tcol_reg) :
                        tile_addr(RW'(cell_row), CW'(cell_col));
        fwd_addr_reg <= cnt_waddr;
        fwd_data_reg <= cnt_wdata;

        // step query: divide by the cell size through the reciprocal
        if (step_acc)
        begin
            prod_fx_reg <= PW'(from_x[9:0]) * PW'(RECIP);
            prod_fy_reg <= PW'(from_y[9:0]) * PW'(RECIP);
            prod_tx_reg <= PW'(to_x[9:0]) * PW'(RECIP);
            prod_ty_reg <= PW'(to_y[9:0]) * PW'(RECIP);
            neg_fx_reg  <= from_x[10];
            neg_fy_reg  <= from_y[10];
            neg_tx_reg  <= to_x[10];
            neg_ty_reg  <= to_y[10];
            tie_reg     <= tie_pick;
        end

        // clamp to tiles
        if (state_reg == S_TILE)
        begin
            sj_reg <= CW'(clamp_tile(neg_fx_reg, prod_fx_reg, 10'(GRID_COLS)));
            si_reg <= RW'(clamp_tile(neg_fy_reg, prod_fy_reg, 10'(GRID_ROWS)));
            ej_reg <= CW'(clamp_tile(neg_tx_reg, prod_tx_reg, 10'(GRID_COLS)));
            ei_reg <= RW'(clamp_tile(neg_ty_reg, prod_ty_reg, 10'(GRID_ROWS)));
        end

        // neighbour responses
        rsp_k_reg <= rd_k_reg[1:0];
        if (rsp_vld_reg)
        begin
            cand_reg[rsp_k_reg] <= nb_in[rsp_k_reg] && (tile_rdata == TILE_EMPTY);
            cost_reg[rsp_k_reg] <= nb_cost[rsp_k_reg];
        end

        if (state_reg == S_MIN)
        begin
            tie_mask_reg <= min_tie;
            tcnt_reg     <= min_cnt;
        end

        // result register
        if ((state_reg == S_SEL) && out_free)
        begin
            out_row_reg   <= sel_found ? nb_r[sel_k] : si_reg;
            out_col_reg   <= sel_found ? nb_c[sel_k] : sj_reg;
            out_moved_reg <= sel_found;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_row  = 4'(out_row_reg);
    assign next_col  = 4'(out_col_reg);
    assign moved     = out_moved_reg;

    // Tile state map
    occgs_ram #(
        .WIDTH (TILE_W),
        .DEPTH (TILES)
    ) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_wdata),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (tile_rdata)
    );

    // Per-column black pixel counts
    occgs_ram #(
        .WIDTH (KW),
        .DEPTH (GRID_COLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (pix_acc),
        .raddr (tcol_reg),
        .rdata (cnt_rdata)
    );

    // Neighbour reads never collide with a tile map write
    assert property (@(posedge clk) disable iff (!rst_n) !(tile_we && tile_re))
        else $error("tile map read and write in the same cycle");

    // A tile's count never exceeds its pixel count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && s1_pix_reg) |-> (cnt_sum <= KW'(NPIX)))
        else $error("black count overflow");

    // A chosen tile is a 4-neighbour of the start tile
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEL) && out_free && sel_found) |=>
        (((out_row_reg == si_reg) &&
          ((out_col_reg == sj_reg + CW'(1)) || (out_col_reg + CW'(1) == sj_reg))) ||
         ((out_col_reg == sj_reg) &&
          ((out_row_reg == si_reg + RW'(1)) || (out_row_reg + RW'(1) == si_reg)))))
        else $error("chosen tile is not adjacent to the start tile");

endmodule
